FILE: rtl/core/pfs_pkg.sv
`timescale 1ns / 1ps

package pfs_pkg;

  localparam int FREQ_W    = 11;
  localparam int SETTING_W = 7;
  localparam int FIELD_W   = 3;

  localparam logic [FREQ_W-1:0] FREQ_MAX = 11'h7FF;

  // op codes carried by an input word
  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic              op;
    logic [FREQ_W-1:0] frequency;
  } pfs_item_t;

  typedef struct packed {
    logic              freq_write;
    logic [FREQ_W-1:0] new_frequency;
    logic              osc_disable;
  } pfs_result_t;

endpackage

FILE: rtl/core/pfs_stream_if.sv
`timescale 1ns / 1ps

interface pfs_in_if import pfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [FREQ_W-1:0] frequency;

  modport source (output valid, output op, output frequency, input ready);
  modport sink   (input valid, input op, input frequency, output ready);
endinterface

interface pfs_out_if import pfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              freq_write;
  logic [FREQ_W-1:0] new_frequency;
  logic              osc_disable;

  modport source (output valid, output freq_write, output new_frequency,
                  output osc_disable, input ready);
  modport sink   (input valid, input freq_write, input new_frequency,
                  input osc_disable, output ready);
endinterface

FILE: rtl/core/pfs_sweep_unit.sv
`timescale 1ns / 1ps

module pfs_sweep_unit
  import pfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  pfs_item_t            item,
  input  logic [SETTING_W-1:0] setting,
  output pfs_result_t          result
);

  logic [FIELD_W-1:0] tick_count;
  logic [FIELD_W-1:0] shift_amount;
  logic               subtract_mode;
  logic [FIELD_W-1:0] sweep_period;
  logic [FREQ_W-1:0]  shadow_freq;

  logic [FIELD_W-1:0] tick_count_next;
  logic [FREQ_W-1:0]  shadow_freq_next;

  logic [FIELD_W:0]   tick_inc;
  logic [FREQ_W-1:0]  delta;
  logic [FREQ_W:0]    sum;
  logic               wrap;

  assign tick_inc = {1'b0, tick_count} + {{FIELD_W{1'b0}}, 1'b1};
  assign wrap     = tick_inc >= {1'b0, sweep_period};
  assign delta    = shadow_freq >> shift_amount;
  assign sum      = {1'b0, shadow_freq} + {1'b0, delta};

  always_comb begin
    result           = '0;
    tick_count_next  = tick_count;
    shadow_freq_next = shadow_freq;
    if (item.op == OP_TICK && sweep_period != '0) begin
      if (wrap) begin
        tick_count_next = '0;
        if (shift_amount != '0) begin
          if (subtract_mode) begin
            // cannot go negative for a nonzero shift, kept for safety
            if (delta <= shadow_freq) begin
              result.freq_write    = 1'b1;
              result.new_frequency = shadow_freq - delta;
            end
          end else if (sum > {1'b0, FREQ_MAX}) begin
            result.osc_disable = 1'b1;
          end else begin
            result.freq_write    = 1'b1;
            result.new_frequency = sum[FREQ_W-1:0];
          end
          if (result.freq_write) begin
            shadow_freq_next = result.new_frequency;
          end
        end
      end else begin
        tick_count_next = tick_inc[FIELD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      shift_amount  <= '0;
      subtract_mode <= 1'b0;
      sweep_period  <= '0;
      shadow_freq   <= '0;
    end else if (step) begin
      if (item.op == OP_RESTART) begin
        tick_count    <= '0;
        shift_amount  <= setting[FIELD_W-1:0];
        subtract_mode <= setting[FIELD_W];
        sweep_period  <= setting[SETTING_W-1:FIELD_W+1];
        shadow_freq   <= item.frequency;
      end else begin
        tick_count  <= tick_count_next;
        shadow_freq <= shadow_freq_next;
      end
    end
  end

endmodule

FILE: rtl/core/pfs_out_reg.sv
`timescale 1ns / 1ps

module pfs_out_reg
  import pfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic        pop,
  input  pfs_result_t result_in,
  output logic        valid,
  output pfs_result_t result_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

FILE: rtl/core/pulse_frequency_sweep.sv
`timescale 1ns / 1ps

// Frequency sweep unit for a pulse channel.
// item_in carries one word per restart (op = 0, frequency loaded as shadow)
// or per sweep tick (op = 1). word_out returns exactly one word per input
// word: freq_write with new_frequency when the sweep writes a new value,
// osc_disable when an upward sweep overflows, all zeros otherwise.
// The sweep setting is written through cfg_we / cfg_wdata and is picked up
// at the next restart; write it only while no words are in flight.
// An accepted word passes one input register, then the sweep arithmetic
// (one shift and one 12-bit add or 11-bit subtract) into the output
// register. Throughput is one word per cycle when word_out is not stalled.
// When word_out is stalled the output register holds its word; the input
// register still takes one more word, then item_in.ready drops until the
// receiver drains.
// Synchronous reset clears the setting, the sweep state and both valids.
module pulse_frequency_sweep
  import pfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [SETTING_W-1:0] cfg_wdata,
  pfs_in_if.sink               item_in,
  pfs_out_if.source            word_out
);

  logic [SETTING_W-1:0] sweep_setting;
  logic                 in_valid;
  pfs_item_t            in_item;
  logic                 advance;
  pfs_result_t          step_result;
  pfs_result_t          out_result;
  logic                 out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_setting <= '0;
    end else if (cfg_we) begin
      sweep_setting <= cfg_wdata;
    end
  end

  assign advance       = in_valid && (!out_valid || word_out.ready);
  assign item_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.ready) begin
      in_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      in_item.op        <= item_in.op;
      in_item.frequency <= item_in.frequency;
    end
  end

  pfs_sweep_unit u_sweep (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (in_item),
    .setting (sweep_setting),
    .result  (step_result)
  );

  pfs_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .pop        (word_out.ready),
    .result_in  (step_result),
    .valid      (out_valid),
    .result_out (out_result)
  );

  assign word_out.valid         = out_valid;
  assign word_out.freq_write    = out_result.freq_write;
  assign word_out.new_frequency = out_result.new_frequency;
  assign word_out.osc_disable   = out_result.osc_disable;

endmodule

FILE: rtl/core/pfs_checker.sv
`timescale 1ns / 1ps

module pfs_checker
  import pfs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              freq_write,
  input logic [FREQ_W-1:0] new_frequency,
  input logic              osc_disable
);

  // a stalled word stays valid with its new_frequency unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_frequency))
    else $error("output word dropped or changed under stall");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(freq_write && osc_disable))
    else $error("write and disable flagged together");

  a_zero_freq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !freq_write |-> new_frequency == '0)
    else $error("frequency nonzero without a write");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind pulse_frequency_sweep pfs_checker u_pfs_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (word_out.valid),
  .out_ready     (word_out.ready),
  .freq_write    (word_out.freq_write),
  .new_frequency (word_out.new_frequency),
  .osc_disable   (word_out.osc_disable)
);
